### hdl/csu_pkg.sv
// ----------------------------------------------------------------------------
// csu_pkg
// Constants and the character table shared by the callsign unpacker.
// ----------------------------------------------------------------------------
package csu_pkg;

    localparam int CODE_W = 28;
    localparam int CHAR_W = 7;
    localparam int LEN_W = 3;
    localparam int NUM_CHARS = 6;

    localparam logic [CODE_W-1:0] CODE_LIMIT = 28'd262177560;

    localparam int DIV_LETTER = 27;
    localparam int DIV_DIGIT = 10;
    localparam int DIV_ALNUM = 36;

    localparam int Q1_W = 24;
    localparam int Q2_W = 19;
    localparam int Q3_W = 14;
    localparam int Q4_W = 11;
    localparam int Q5_W = 6;

    localparam logic [5:0] IDX_FIRST_LETTER = 6'd10;
    localparam logic [5:0] IDX_SPACE = 6'd36;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;

    typedef logic [CHAR_W-1:0] char_t;

    // Maps an index of the alphabet 0-9, A-Z, space to its ASCII code.
    function automatic char_t csu_char(input logic [5:0] idx);
        char_t ch;
        if (idx < IDX_FIRST_LETTER) begin
            ch = ASCII_ZERO + CHAR_W'(idx);
        end else if (idx < IDX_SPACE) begin
            ch = ASCII_A + CHAR_W'(idx - IDX_FIRST_LETTER);
        end else begin
            ch = ASCII_SPACE;
        end
        return ch;
    endfunction

endpackage

### hdl/csu_div_stage.sv
// ----------------------------------------------------------------------------
// csu_div_stage
// Two-stage division by a constant: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
module csu_div_stage #(
    parameter int IN_W = 28,
    parameter int Q_W = 24,
    parameter int DIV = 27,
    parameter int SIDE_W = 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [IN_W-1:0]                    x,
    input  logic [SIDE_W-1:0]                  side_in,
    output logic                               out_valid,
    output logic [Q_W-1:0]                     q,
    output logic [SIDE_W+$clog2(DIV)-1:0]      side_out
);

    localparam int R_W = $clog2(DIV);
    localparam int P_W = 2 * IN_W;
    localparam logic [IN_W-1:0] MAGIC = IN_W'((64'd1 << IN_W) / DIV);

    logic              a_valid_reg;
    logic [IN_W-1:0]   a_x_reg;
    logic [P_W-1:0]    a_prod_reg;
    logic [SIDE_W-1:0] a_side_reg;
    logic [P_W-1:0]    a_prod_next;

    logic              b_valid_reg;
    logic [Q_W-1:0]    b_q_reg;
    logic [R_W-1:0]    b_r_reg;
    logic [SIDE_W-1:0] b_side_reg;
    logic [Q_W-1:0]    b_q_next;
    logic [R_W-1:0]    b_r_next;

    logic [Q_W-1:0]    q_est;
    logic [IN_W-1:0]   qd;
    logic [IN_W-1:0]   r_est;
    logic              fix;

    // The estimate is never above the true quotient and at most one below.
    assign a_prod_next = P_W'(x) * P_W'(MAGIC);

    assign q_est = a_prod_reg[IN_W+Q_W-1:IN_W];
    assign qd = IN_W'(q_est) * IN_W'(DIV);
    assign r_est = a_x_reg - qd;
    assign fix = (r_est >= IN_W'(DIV));
    assign b_q_next = fix ? (q_est + Q_W'(1)) : q_est;
    assign b_r_next = fix ? R_W'(r_est - IN_W'(DIV)) : R_W'(r_est);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x_reg    <= x;
            a_prod_reg <= a_prod_next;
            a_side_reg <= side_in;
            b_q_reg    <= b_q_next;
            b_r_reg    <= b_r_next;
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign q = b_q_reg;
    assign side_out = {b_side_reg, b_r_reg};

endmodule

### hdl/callsign_unpack.sv
// ----------------------------------------------------------------------------
// callsign_unpack
// Decodes a 28-bit packed callsign into six ASCII characters and a length.
// ----------------------------------------------------------------------------
// The input channel (s_valid, s_ready, s_packed_call) takes one packed code
// per beat. The result channel (m_valid, m_ready, m_*) returns one beat per
// input beat, in order: the valid flag, six characters with spaces as zero,
// and the number of characters before the first zero.
// The code is split by five divisions by constants (27, 27, 27, 10, 36).
// Each division is a reciprocal multiply followed by one correction step,
// two register stages each, and one more stage builds the characters.
// Throughput is one beat per cycle unless the receiver stalls, through the eleven-stage pipeline.
// When the receiver stalls, the whole pipeline holds and s_ready falls once
// the output register is full; no beat is lost or repeated.
// Reset empties the pipeline and clears m_valid; the data registers are not reset.
// ----------------------------------------------------------------------------
module callsign_unpack
    import csu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CODE_W-1:0]   s_packed_call,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_valid_res,
    output logic [CHAR_W-1:0]   m_char_0,
    output logic [CHAR_W-1:0]   m_char_1,
    output logic [CHAR_W-1:0]   m_char_2,
    output logic [CHAR_W-1:0]   m_char_3,
    output logic [CHAR_W-1:0]   m_char_4,
    output logic [CHAR_W-1:0]   m_char_5,
    output logic [LEN_W-1:0]    m_call_length
);

    localparam int R1_W = $clog2(DIV_LETTER);
    localparam int R4_W = $clog2(DIV_DIGIT);
    localparam int R5_W = $clog2(DIV_ALNUM);
    localparam int S1_W = 1 + R1_W;
    localparam int S2_W = S1_W + R1_W;
    localparam int S3_W = S2_W + R1_W;
    localparam int S4_W = S3_W + R4_W;
    localparam int S5_W = S4_W + R5_W;

    logic en;
    logic bad;

    logic            v1, v2, v3, v4, v5;
    logic [Q1_W-1:0] q1;
    logic [Q2_W-1:0] q2;
    logic [Q3_W-1:0] q3;
    logic [Q4_W-1:0] q4;
    logic [Q5_W-1:0] q5;
    logic [S1_W-1:0] side1;
    logic [S2_W-1:0] side2;
    logic [S3_W-1:0] side3;
    logic [S4_W-1:0] side4;
    logic [S5_W-1:0] side5;

    logic            f_bad;
    logic [R1_W-1:0] f_r1, f_r2, f_r3;
    logic [R4_W-1:0] f_r4;
    logic [R5_W-1:0] f_r5;

    char_t raw [NUM_CHARS];
    char_t shown [NUM_CHARS];
    char_t chars_next [NUM_CHARS];
    char_t chars_reg [NUM_CHARS];
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_reg;
    logic             valid_res_next;
    logic             valid_res_reg;
    logic             m_valid_reg;
    logic             lead_space;

    assign en = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign bad = (s_packed_call >= CODE_LIMIT);

    csu_div_stage #(.IN_W(CODE_W), .Q_W(Q1_W), .DIV(DIV_LETTER), .SIDE_W(1)) u_div1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid && s_ready), .x(s_packed_call), .side_in(bad),
        .out_valid(v1), .q(q1), .side_out(side1)
    );

    csu_div_stage #(.IN_W(Q1_W), .Q_W(Q2_W), .DIV(DIV_LETTER), .SIDE_W(S1_W)) u_div2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v1), .x(q1), .side_in(side1),
        .out_valid(v2), .q(q2), .side_out(side2)
    );

    csu_div_stage #(.IN_W(Q2_W), .Q_W(Q3_W), .DIV(DIV_LETTER), .SIDE_W(S2_W)) u_div3 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v2), .x(q2), .side_in(side2),
        .out_valid(v3), .q(q3), .side_out(side3)
    );

    csu_div_stage #(.IN_W(Q3_W), .Q_W(Q4_W), .DIV(DIV_DIGIT), .SIDE_W(S3_W)) u_div4 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v3), .x(q3), .side_in(side3),
        .out_valid(v4), .q(q4), .side_out(side4)
    );

    csu_div_stage #(.IN_W(Q4_W), .Q_W(Q5_W), .DIV(DIV_ALNUM), .SIDE_W(S4_W)) u_div5 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v4), .x(q4), .side_in(side4),
        .out_valid(v5), .q(q5), .side_out(side5)
    );

    assign {f_bad, f_r1, f_r2, f_r3, f_r4, f_r5} = side5;

    always_comb begin
        raw[0] = csu_char(q5);
        raw[1] = csu_char(6'(f_r5));
        raw[2] = csu_char(6'(f_r4));
        raw[3] = csu_char(IDX_FIRST_LETTER + 6'(f_r3));
        raw[4] = csu_char(IDX_FIRST_LETTER + 6'(f_r2));
        raw[5] = csu_char(IDX_FIRST_LETTER + 6'(f_r1));
        lead_space = (raw[0] == ASCII_SPACE);
        for (int k = 0; k < NUM_CHARS; k++) begin
            char_t ch;
            if (!lead_space) begin
                ch = raw[k];
            end else if (k < NUM_CHARS - 1) begin
                ch = raw[k + 1];
            end else begin
                ch = ASCII_SPACE;
            end
            shown[k] = (ch == ASCII_SPACE) ? '0 : ch;
        end
        len_next = LEN_W'(NUM_CHARS);
        for (int k = NUM_CHARS - 1; k >= 0; k--) begin
            if (shown[k] == '0) begin
                len_next = LEN_W'(k);
            end
        end
        for (int k = 0; k < NUM_CHARS; k++) begin
            chars_next[k] = f_bad ? '0 : shown[k];
        end
        if (f_bad) begin
            len_next = '0;
        end
        valid_res_next = !f_bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v5;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chars_reg     <= chars_next;
            len_reg       <= len_next;
            valid_res_reg <= valid_res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_valid_res = valid_res_reg;
    assign m_char_0 = chars_reg[0];
    assign m_char_1 = chars_reg[1];
    assign m_char_2 = chars_reg[2];
    assign m_char_3 = chars_reg[3];
    assign m_char_4 = chars_reg[4];
    assign m_char_5 = chars_reg[5];
    assign m_call_length = len_reg;

endmodule
